// ----- design/ilod_pkg.sv -----
`timescale 1ns / 1ps

package ilod_pkg;

  localparam int STORE_DEPTH = 6;

  localparam logic [2:0] LEN_SHORT = 3'd2;
  localparam logic [2:0] LEN_MID   = 3'd4;
  localparam logic [2:0] LEN_LONG  = 3'd6;

  localparam logic [3:0] NIB_SHORT_MAX = 4'h3;
  localparam logic [3:0] NIB_MID_MAX   = 4'hB;
  localparam logic [7:0] LOW_NIB_MASK  = 8'h0F;

  // first-byte codes that widen the opcode
  localparam logic [7:0] OP_00 = 8'h00;
  localparam logic [7:0] OP_01 = 8'h01;
  localparam logic [7:0] OP_A5 = 8'hA5;
  localparam logic [7:0] OP_A7 = 8'hA7;
  localparam logic [7:0] OP_B2 = 8'hB2;
  localparam logic [7:0] OP_B3 = 8'hB3;
  localparam logic [7:0] OP_B9 = 8'hB9;
  localparam logic [7:0] OP_C0 = 8'hC0;
  localparam logic [7:0] OP_C2 = 8'hC2;
  localparam logic [7:0] OP_C4 = 8'hC4;
  localparam logic [7:0] OP_C6 = 8'hC6;
  localparam logic [7:0] OP_C8 = 8'hC8;
  localparam logic [7:0] OP_CC = 8'hCC;
  localparam logic [7:0] OP_E3 = 8'hE3;
  localparam logic [7:0] OP_E5 = 8'hE5;
  localparam logic [7:0] OP_E6 = 8'hE6;
  localparam logic [7:0] OP_E7 = 8'hE7;
  localparam logic [7:0] OP_EB = 8'hEB;
  localparam logic [7:0] OP_EC = 8'hEC;
  localparam logic [7:0] OP_ED = 8'hED;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       restart;
  } in_word_t;

  typedef struct packed {
    logic [15:0] opcode_value;
    logic [2:0]  instr_length;
    logic [47:0] instr_bytes;
    logic [31:0] start_offset;
  } out_word_t;

  // one assembled instruction, front to back
  typedef struct packed {
    logic [47:0] instr_bytes;
    logic [2:0]  instr_length;
    logic [31:0] start_offset;
  } instr_entry_t;

  typedef struct packed {
    logic         push;
    instr_entry_t entry;
  } push_req_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  function automatic logic [2:0] length_of(input logic [7:0] first);
    logic [3:0] nib;
    nib = first[7:4];
    if (nib <= NIB_SHORT_MAX) begin
      return LEN_SHORT;
    end else if (nib <= NIB_MID_MAX) begin
      return LEN_MID;
    end
    return LEN_LONG;
  endfunction

  function automatic logic [15:0] opcode_of(input logic [47:0] bytes,
                                            input logic [2:0] len);
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b5;
    logic [15:0] wide;
    logic [15:0] nib_ext;
    logic [15:0] plain;
    logic [15:0] res;
    b0      = bytes[47:40];
    b1      = bytes[39:32];
    b5      = bytes[7:0];
    wide    = {b0, b1};
    nib_ext = {4'h0, b0, b1[3:0] & LOW_NIB_MASK[3:0]};
    plain   = {8'h00, b0};
    res     = plain;
    if (len == LEN_LONG) begin
      unique case (b0) inside
        OP_E3, OP_E6, OP_E7, OP_EB, OP_EC, OP_ED: res = {b0, b5};
        OP_E5:                                    res = wide;
        OP_C0, OP_C2, OP_C4, OP_C6, OP_C8, OP_CC: res = nib_ext;
        default:                                  res = plain;
      endcase
    end else if (len == LEN_MID) begin
      unique case (b0) inside
        OP_B2, OP_B3, OP_B9: res = wide;
        OP_A5, OP_A7:        res = nib_ext;
        default:             res = plain;
      endcase
    end else begin
      unique case (b0) inside
        OP_00, OP_01: res = wide;
        default:      res = plain;
      endcase
    end
    return res;
  endfunction

endpackage

// ----- design/instruction_length_opcode_decode_unit.sv -----
`timescale 1ns / 1ps

// Instruction length and opcode decoder. Takes one code byte per cycle with no
// bubbles and emits one word per complete instruction (2, 4 or 6 bytes, set by
// the first byte's high nibble): packed bytes, length, start offset and opcode.
// The front end collects bytes and sizes the instruction; a 2-entry queue
// feeds the back end, which extracts the opcode into the output register. A
// result passes a queue slot, then the output register. restart drops any
// partial instruction and zeroes the offset before its byte; the offset wraps
// at 32 bits, and an unfinished trailing instruction is never emitted. Input
// stalls only when the queue is full, i.e. after the output has been stalled.

module instruction_length_opcode_decode_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 src_valid,
  output logic                 src_stall,
  input  ilod_pkg::in_word_t   src_word,
  output logic                 dst_valid,
  input  logic                 dst_stall,
  output ilod_pkg::out_word_t  dst_word
);

  ilod_pkg::push_req_t     q_push;
  ilod_pkg::queue_status_t q_status;
  ilod_pkg::instr_entry_t  head;
  logic                    pop;

  ilod_front u_front (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_word  (src_word),
    .q_status  (q_status),
    .q_push    (q_push)
  );

  ilod_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .q_push   (q_push),
    .pop      (pop),
    .head     (head),
    .q_status (q_status)
  );

  ilod_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_status  (q_status),
    .pop       (pop),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall),
    .dst_word  (dst_word)
  );

endmodule

// ----- design/ilod_front.sv -----
`timescale 1ns / 1ps

module ilod_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     src_valid,
  output logic                     src_stall,
  input  ilod_pkg::in_word_t       src_word,
  input  ilod_pkg::queue_status_t  q_status,
  output ilod_pkg::push_req_t      q_push
);

  logic [7:0]  byte_store [ilod_pkg::STORE_DEPTH];
  logic [2:0]  bytes_held;
  logic [2:0]  expected_length;
  logic [31:0] stream_offset;

  logic        accept;
  logic [2:0]  cur_held;
  logic [31:0] cur_off;
  logic        start_new;
  logic [2:0]  len_cur;
  logic [2:0]  idx;
  logic [2:0]  held_inc;
  logic        done;
  logic [47:0] packed_bytes;

  assign src_stall = q_status.full;
  assign accept    = src_valid && !src_stall;

  always_comb begin
    cur_held  = src_word.restart ? 3'd0 : bytes_held;
    cur_off   = src_word.restart ? 32'd0 : stream_offset;
    start_new = (cur_held == 3'd0) || (cur_held >= 3'(ilod_pkg::STORE_DEPTH));
    len_cur   = start_new ? ilod_pkg::length_of(src_word.code_byte) : expected_length;
    idx       = start_new ? 3'd0 : cur_held;
    held_inc  = idx + 3'd1;
    done      = held_inc >= len_cur;
    for (int i = 0; i < ilod_pkg::STORE_DEPTH; i++) begin
      // incoming byte overrides its slot; slots past the length read zero
      if (3'(i) >= len_cur) begin
        packed_bytes[47 - 8*i -: 8] = 8'h00;
      end else if (3'(i) == idx) begin
        packed_bytes[47 - 8*i -: 8] = src_word.code_byte;
      end else begin
        packed_bytes[47 - 8*i -: 8] = byte_store[i];
      end
    end
  end

  always_comb begin
    q_push.push               = accept && done;
    q_push.entry.instr_bytes  = packed_bytes;
    q_push.entry.instr_length = len_cur;
    q_push.entry.start_offset = cur_off;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_held      <= 3'd0;
      expected_length <= 3'd0;
      stream_offset   <= 32'd0;
    end else if (accept) begin
      if (done) begin
        bytes_held      <= 3'd0;
        expected_length <= 3'd0;
        stream_offset   <= cur_off + 32'(len_cur);
      end else begin
        bytes_held      <= held_inc;
        expected_length <= len_cur;
        stream_offset   <= cur_off;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_store[idx] <= src_word.code_byte;
    end
  end

endmodule

// ----- design/ilod_queue.sv -----
`timescale 1ns / 1ps

module ilod_queue (
  input  logic                     clk,
  input  logic                     rst,
  input  ilod_pkg::push_req_t      q_push,
  input  logic                     pop,
  output ilod_pkg::instr_entry_t   head,
  output ilod_pkg::queue_status_t  q_status
);

  ilod_pkg::instr_entry_t slot [2];
  logic [1:0] count;
  logic [1:0] wr_pos;

  assign head           = slot[0];
  assign q_status.full  = count == 2'd2;
  assign q_status.empty = count == 2'd0;
  assign wr_pos         = count - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count + {1'b0, q_push.push} - {1'b0, pop};
    end
  end

  // head sits in slot 0; a pop shifts slot 1 down
  always_ff @(posedge clk) begin
    if (q_push.push && wr_pos == 2'd0) begin
      slot[0] <= q_push.entry;
    end else if (pop) begin
      slot[0] <= slot[1];
    end
    if (q_push.push && wr_pos == 2'd1) begin
      slot[1] <= q_push.entry;
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= 2'd2) else $error("queue count out of range");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push.push |-> !q_status.full) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_status.empty) else $error("pop from empty queue");
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (q_push.push && !pop) |=> count == $past(count) + 2'd1)
    else $error("queue count did not advance on push");
`endif

endmodule

// ----- design/ilod_back.sv -----
`timescale 1ns / 1ps

module ilod_back (
  input  logic                     clk,
  input  logic                     rst,
  input  ilod_pkg::instr_entry_t   head,
  input  ilod_pkg::queue_status_t  q_status,
  output logic                     pop,
  output logic                     dst_valid,
  input  logic                     dst_stall,
  output ilod_pkg::out_word_t      dst_word
);

  logic take;

  assign take = !q_status.empty && (!dst_valid || !dst_stall);
  assign pop  = take;

  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
    end else if (take) begin
      dst_valid <= 1'b1;
    end else if (!dst_stall) begin
      dst_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      dst_word.opcode_value <= ilod_pkg::opcode_of(head.instr_bytes, head.instr_length);
      dst_word.instr_length <= head.instr_length;
      dst_word.instr_bytes  <= head.instr_bytes;
      dst_word.start_offset <= head.start_offset;
    end
  end

endmodule

// ----- tb/sv/instr_decode_checker.sv -----
`timescale 1ns / 1ps

module instr_decode_checker
  import ilod_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      src_valid,
  input  logic      src_stall,
  input  in_word_t  src_word,
  input  logic      dst_valid,
  input  logic      dst_stall,
  input  out_word_t dst_word,
  output int        errors,
  output int        pending
);

  out_word_t   awaited_instrs[$];
  logic [7:0]  frag_bytes [STORE_DEPTH];
  logic [2:0]  frag_count;
  logic [2:0]  frag_length;
  logic [31:0] next_offset;
  int          error_count = 0;
  int          awaited_count = 0;

  assign errors  = error_count;
  assign pending = awaited_count;

  function automatic logic [15:0] decode_opcode(logic [7:0] b0, logic [7:0] b1,
                                                logic [7:0] b5, logic [2:0] len);
    logic [15:0] op;
    op = {8'h00, b0};
    if (len == LEN_LONG) begin
      case (b0)
        OP_E3, OP_E6, OP_E7, OP_EB, OP_EC, OP_ED: op = {b0, b5};
        OP_E5:                                    op = {b0, b1};
        OP_C0, OP_C2, OP_C4, OP_C6, OP_C8, OP_CC: op = {4'h0, b0, b1[3:0]};
        default: ;
      endcase
    end else if (len == LEN_MID) begin
      case (b0)
        OP_B2, OP_B3, OP_B9: op = {b0, b1};
        OP_A5, OP_A7:        op = {4'h0, b0, b1[3:0]};
        default: ;
      endcase
    end else if (b0 == OP_00 || b0 == OP_01) begin
      op = {b0, b1};
    end
    return op;
  endfunction

  task automatic report(string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic take_byte(in_word_t w);
    logic [7:0]  b;
    logic [47:0] packed_bytes;
    out_word_t   instr;
    b = w.code_byte;
    if (w.restart) begin
      frag_count  = '0;
      frag_length = '0;
      next_offset = '0;
    end
    if (frag_count == 0 || frag_count >= STORE_DEPTH) begin
      frag_count  = '0;
      frag_length = (b[7:4] <= NIB_SHORT_MAX) ? LEN_SHORT :
                    (b[7:4] <= NIB_MID_MAX)   ? LEN_MID   : LEN_LONG;
    end
    frag_bytes[frag_count] = b;
    frag_count = frag_count + 3'd1;
    if (frag_count >= frag_length) begin
      packed_bytes = '0;
      for (int i = 0; i < STORE_DEPTH; i++) begin
        if (i < frag_length) packed_bytes[47 - 8*i -: 8] = frag_bytes[i];
      end
      // byte 5 is only looked at for 6-byte instructions
      instr.opcode_value = decode_opcode(frag_bytes[0], frag_bytes[1], frag_bytes[5],
                                         frag_length);
      instr.instr_length = frag_length;
      instr.instr_bytes  = packed_bytes;
      instr.start_offset = next_offset;
      awaited_instrs.push_back(instr);
      next_offset = next_offset + 32'(frag_length);
      frag_count  = '0;
      frag_length = '0;
    end
  endtask

  task automatic check_word(out_word_t got);
    out_word_t want;
    if (awaited_instrs.size() == 0) begin
      report($sformatf("unexpected word op=%h len=%0d bytes=%h off=%h",
                       got.opcode_value, got.instr_length, got.instr_bytes,
                       got.start_offset));
      return;
    end
    want = awaited_instrs.pop_front();
    if (got.opcode_value !== want.opcode_value)
      report($sformatf("opcode_value %h, expected %h (off %h)",
                       got.opcode_value, want.opcode_value, want.start_offset));
    if (got.instr_length !== want.instr_length)
      report($sformatf("instr_length %0d, expected %0d (off %h)",
                       got.instr_length, want.instr_length, want.start_offset));
    if (got.instr_bytes !== want.instr_bytes)
      report($sformatf("instr_bytes %h, expected %h (off %h)",
                       got.instr_bytes, want.instr_bytes, want.start_offset));
    if (got.start_offset !== want.start_offset)
      report($sformatf("start_offset %h, expected %h",
                       got.start_offset, want.start_offset));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      frag_count  = '0;
      frag_length = '0;
      next_offset = '0;
      awaited_instrs.delete();
    end else begin
      if (src_valid && !src_stall) take_byte(src_word);
      if (dst_valid && !dst_stall) check_word(dst_word);
    end
    awaited_count = awaited_instrs.size();
  end

endmodule

// ----- tb/sv/instruction_length_opcode_decode_unit_tb.sv -----
`timescale 1ns / 1ps

module instruction_length_opcode_decode_unit_tb;
  import ilod_pkg::*;

  localparam int RANDOM_BYTES = 400;
  localparam int QUIET_FROM   = 320;
  localparam int CYCLE_LIMIT  = 200000;

  // first bytes whose opcode pulls in bits of a later byte
  localparam logic [7:0] WIDE_FIRSTS [20] = '{
    OP_00, OP_01, OP_A5, OP_A7, OP_B2, OP_B3, OP_B9, OP_C0, OP_C2, OP_C4,
    OP_C6, OP_C8, OP_CC, OP_E3, OP_E5, OP_E6, OP_E7, OP_EB, OP_EC, OP_ED
  };

  // {code_byte, restart}
  localparam logic [8:0] DIRECTED [26] = '{
    {8'h00, 1'b1}, {8'h12, 1'b0},
    {8'h3F, 1'b0}, {8'h80, 1'b0},
    {8'hB9, 1'b0}, {8'hA5, 1'b0}, {8'h00, 1'b0}, {8'hFF, 1'b0},
    {8'hA7, 1'b0}, {8'h3C, 1'b0}, {8'h11, 1'b0}, {8'h22, 1'b0},
    {8'h4C, 1'b0}, {8'h55, 1'b0},
    {8'hC0, 1'b1}, {8'hF5, 1'b0}, {8'h00, 1'b0}, {8'h00, 1'b0}, {8'h00, 1'b0},
    {8'h00, 1'b0},
    {8'hFF, 1'b0}, {8'h01, 1'b0}, {8'h02, 1'b0}, {8'h03, 1'b0}, {8'h04, 1'b0},
    {8'hFF, 1'b0}
  };

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      src_valid = 1'b0;
  logic      src_stall;
  in_word_t  src_word = '0;
  logic      dst_valid;
  logic      dst_stall = 1'b0;
  out_word_t dst_word;

  int errors;
  int pending;
  int cycle_count = 0;
  int random_sent = 0;
  bit quiet = 1'b0;
  bit restart_next = 1'b0;
  bit drained_mid = 1'b0;

  instruction_length_opcode_decode_unit uut (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_word  (src_word),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall),
    .dst_word  (dst_word)
  );

  instr_decode_checker checker_i (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_word  (src_word),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall),
    .dst_word  (dst_word),
    .errors    (errors),
    .pending   (pending)
  );

  always #2 clk = ~clk;

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // output side back-pressure: stall bursts and free-running stretches
  initial begin
    int burst;
    forever begin
      if (quiet || rst) begin
        dst_stall <= 1'b0;
        @(posedge clk);
      end else begin
        if ($urandom_range(0, 2) == 0) begin
          burst = $urandom_range(1, 15);
          dst_stall <= 1'b1;
        end else begin
          burst = $urandom_range(1, 40);
          dst_stall <= 1'b0;
        end
        repeat (burst) @(posedge clk);
      end
    end
  end

  task automatic send_byte(logic [7:0] b, logic rs);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      src_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    src_word  <= '{code_byte: b, restart: rs};
    src_valid <= 1'b1;
    do @(posedge clk); while (src_stall);
  endtask

  task automatic hold_until_drained();
    src_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // mostly whole instructions; some lone noise bytes and cut-off instructions
  task automatic send_random_instr();
    int         kind;
    int         len;
    int         cut;
    logic [7:0] lead;
    logic       rs;
    kind = $urandom_range(0, 9);
    rs = restart_next || ($urandom_range(0, 19) == 0);
    restart_next = 1'b0;
    if (kind == 0) begin
      send_byte(8'($urandom), rs);
      random_sent++;
      restart_next = 1'($urandom_range(0, 1));
      return;
    end
    lead = $urandom_range(0, 1) ? WIDE_FIRSTS[$urandom_range(0, 19)] : 8'($urandom);
    len = (lead[7:4] <= NIB_SHORT_MAX) ? 2 : (lead[7:4] <= NIB_MID_MAX) ? 4 : 6;
    cut = (kind == 1) ? $urandom_range(1, len - 1) : len;
    send_byte(lead, rs);
    for (int i = 1; i < cut; i++) send_byte(8'($urandom), 1'b0);
    random_sent += cut;
    if (kind == 1) restart_next = 1'b1;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < 26; i++) send_byte(DIRECTED[i][8:1], DIRECTED[i][0]);
    hold_until_drained();
    while (random_sent < RANDOM_BYTES) begin
      if (!drained_mid && random_sent >= RANDOM_BYTES / 2) begin
        hold_until_drained();
        drained_mid = 1'b1;
      end
      if (random_sent >= QUIET_FROM) quiet = 1'b1;
      send_random_instr();
    end
    src_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
